>>> src/att_pkg.sv
// Shared types, character codes and defaults for the text terminal grid block.
package att_pkg;

  // Default sizes handed to the top level parameters
  localparam int SCROLLBACK_ROWS_DEF = 128;
  localparam int MAX_COLS_DEF        = 160;
  localparam int PARAM_CHARS_DEF     = 15;

  // Configuration port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_COLS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_ROWS = 8'd1;
  localparam logic [7:0] VISIBLE_COLS_RST = 8'd60;
  localparam logic [7:0] VISIBLE_ROWS_RST = 8'd20;

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Parameter digit handling
  localparam int PCNT_W = 4;
  localparam logic [7:0] PARAM_SAT = 8'd255;

  typedef enum logic [1:0] {
    PM_NORMAL = 2'd0,
    PM_ESC    = 2'd1,
    PM_CSI    = 2'd2
  } pmode_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_RD,
    SQ_CLR,
    SQ_SCR,
    SQ_SCRW,
    SQ_FIN
  } sq_state_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic [6:0] read_row;
    logic [7:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cursor_row_out;
    logic [7:0] cursor_col_out;
    logic [7:0] rows_in_use;
    logic [1:0] parser_mode;
  } out_item_t;

  // Grid work requested by the parser for one put
  typedef struct packed {
    logic       wr;
    logic [7:0] wdata;
    logic       clr_all;
    logic       clr_line;
    logic       scroll;
  } job_t;

endpackage

>>> src/att_grid_ram.sv
// Character grid storage: one write port, one registered read port.
module att_grid_ram #(
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Write the cell
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/att_parser.sv
// Byte parser: cursor, row count, escape state and grid work for each put.
module att_parser #(
  parameter int ROWS   = 128,
  parameter int PCHARS = 15,
  parameter int RW     = 8,
  parameter int CW     = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    ch,
  input  logic [CW-1:0] cols_eff,
  input  logic [RW-1:0] rows_eff,
  output att_pkg::job_t job,
  output logic [RW-1:0] job_row,
  output logic [CW-1:0] job_col,
  output logic [RW-1:0] cur_row,
  output logic [CW-1:0] cur_col,
  output logic [RW-1:0] act_rows,
  output logic [1:0]    mode
);

  att_pkg::pmode_t mode_r, mode_nxt;
  logic [att_pkg::PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [7:0] fp_r, fp_nxt, sp_r, sp_nxt;
  logic sep_r, sep_nxt;
  logic [RW-1:0] row_r, row_nxt, act_r, act_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic is_dig, is_semi;
  logic [7:0] nr, nc;

  function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [7:0] c);
    logic [11:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {4'b0000, c - att_pkg::CH_DIG0};
    return (t > 12'(att_pkg::PARAM_SAT)) ? att_pkg::PARAM_SAT : t[7:0];
  endfunction

  assign is_dig  = (ch >= att_pkg::CH_DIG0) && (ch <= att_pkg::CH_DIG9);
  assign is_semi = (ch == att_pkg::CH_SEMI);
  assign nr      = (fp_r != 8'd0) ? fp_r - 8'd1 : 8'd0;
  assign nc      = (sp_r != 8'd0) ? sp_r - 8'd1 : 8'd0;

  // Decode the byte and settle the cursor
  always_comb begin
    mode_nxt = mode_r;
    pcnt_nxt = pcnt_r;
    fp_nxt   = fp_r;
    sp_nxt   = sp_r;
    sep_nxt  = sep_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    act_nxt  = act_r;
    job      = '0;
    job_row  = row_r;
    job_col  = col_r;
    unique case (mode_r)
      att_pkg::PM_ESC: begin
        mode_nxt = (ch == att_pkg::CH_LBRK) ? att_pkg::PM_CSI : att_pkg::PM_NORMAL;
      end
      att_pkg::PM_CSI: begin
        if (is_dig || is_semi) begin
          if (32'(pcnt_r) < PCHARS) begin
            pcnt_nxt = pcnt_r + 1'b1;
            if (is_semi) begin
              sep_nxt = 1'b1;
            end else if (sep_r) begin
              sp_nxt = add_digit(sp_r, ch);
            end else begin
              fp_nxt = add_digit(fp_r, ch);
            end
          end
        end else begin
          mode_nxt = att_pkg::PM_NORMAL;
          unique case (ch)
            att_pkg::CH_J: begin
              job.clr_all = 1'b1;
              act_nxt = rows_eff;
              row_nxt = '0;
              col_nxt = '0;
            end
            att_pkg::CH_K: begin
              job.clr_line = 1'b1;
            end
            att_pkg::CH_H: begin
              if (32'(nr) < 32'(rows_eff)) row_nxt = RW'(nr);
              if (32'(nc) < 32'(cols_eff)) col_nxt = CW'(nc);
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        mode_nxt = att_pkg::PM_NORMAL;
        if (ch == att_pkg::CH_ESC) begin
          mode_nxt = att_pkg::PM_ESC;
          pcnt_nxt = '0;
          fp_nxt   = '0;
          sp_nxt   = '0;
          sep_nxt  = 1'b0;
        end else if (ch == att_pkg::CH_LF) begin
          row_nxt = row_r + 1'b1;
          col_nxt = '0;
        end else if (ch == att_pkg::CH_CR) begin
          col_nxt = '0;
        end else if (ch == att_pkg::CH_BS) begin
          if (col_r != '0) begin
            col_nxt   = col_r - 1'b1;
            job_col   = col_r - 1'b1;
            job.wr    = 1'b1;
            job.wdata = att_pkg::CH_SPACE;
          end
        end else if (ch >= att_pkg::CH_SPACE && ch <= att_pkg::CH_TILDE) begin
          job.wr    = 1'b1;
          job.wdata = ch;
          col_nxt   = col_r + 1'b1;
        end
      end
    endcase
    // Wrap, scroll and track rows in use
    if (col_nxt >= cols_eff) begin
      col_nxt = '0;
      row_nxt = row_nxt + 1'b1;
    end
    if (32'(row_nxt) >= ROWS) begin
      row_nxt    = RW'(ROWS - 1);
      job.scroll = 1'b1;
    end
    if (row_nxt >= act_nxt) begin
      act_nxt = row_nxt + 1'b1;
    end
  end

  // Hold terminal state, advance on each put
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= att_pkg::PM_NORMAL;
      pcnt_r <= '0;
      fp_r   <= '0;
      sp_r   <= '0;
      sep_r  <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
      act_r  <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      pcnt_r <= pcnt_nxt;
      fp_r   <= fp_nxt;
      sp_r   <= sp_nxt;
      sep_r  <= sep_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      act_r  <= act_nxt;
    end
  end

  assign cur_row  = row_r;
  assign cur_col  = col_r;
  assign act_rows = act_r;
  assign mode     = mode_r;

endmodule

>>> src/att_sweep.sv
// Grid sequencer: single cell access, clear sweeps and the scroll copy, one cell a cycle.
module att_sweep #(
  parameter int ROWS = 128,
  parameter int MAXC = 160,
  parameter int RW   = 8,
  parameter int CW   = 8,
  parameter int AW   = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic          is_read,
  input  logic [6:0]    rd_row,
  input  logic [7:0]    rd_col,
  input  att_pkg::job_t job,
  input  logic [RW-1:0] job_row,
  input  logic [CW-1:0] job_col,
  input  logic [CW-1:0] cols_eff,
  input  logic          out_free,
  output logic          in_ready,
  output logic          out_load,
  output logic [7:0]    rd_char,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata,
  output logic [AW-1:0] raddr,
  input  logic [7:0]    rdata
);

  att_pkg::sq_state_t state_r, state_nxt;
  logic [RW-1:0] sr_r, sr_nxt, er_r, er_nxt;
  logic [CW-1:0] sc_r, sc_nxt, lim_r, lim_nxt;
  logic init_r, init_nxt, spend_r, spend_nxt;
  logic cpv_r, cpv_nxt, rdok_r, rdok_nxt;
  logic [AW-1:0] cpa_r, cpa_nxt;
  logic [7:0] char_r, char_nxt;
  logic [AW-1:0] sweep_addr, job_addr, rd_addr;
  logic row_open, last_row;

  assign sweep_addr = AW'(sr_r) * AW'(MAXC) + AW'(sc_r);
  assign job_addr   = AW'(job_row) * AW'(MAXC) + AW'(job_col);
  assign rd_addr    = AW'(rd_row) * AW'(MAXC) + AW'(rd_col);
  assign row_open   = (sc_r < lim_r);
  assign last_row   = (sr_r == er_r);

  // Next state and sweep counters
  always_comb begin
    state_nxt = state_r;
    sr_nxt    = sr_r;
    er_nxt    = er_r;
    sc_nxt    = sc_r;
    lim_nxt   = lim_r;
    init_nxt  = init_r;
    spend_nxt = spend_r;
    cpv_nxt   = 1'b0;
    cpa_nxt   = cpa_r;
    rdok_nxt  = rdok_r;
    char_nxt  = char_r;
    unique case (state_r)
      att_pkg::SQ_IDLE: begin
        if (take) begin
          char_nxt = 8'd0;
          lim_nxt  = cols_eff;
          sc_nxt   = '0;
          if (is_read) begin
            rdok_nxt  = (32'(rd_row) < ROWS) && (32'(rd_col) < MAXC);
            state_nxt = att_pkg::SQ_RD;
          end else if (job.clr_all) begin
            sr_nxt    = '0;
            er_nxt    = RW'(ROWS - 1);
            state_nxt = att_pkg::SQ_CLR;
          end else if (job.clr_line) begin
            sr_nxt    = job_row;
            er_nxt    = job_row;
            sc_nxt    = job_col;
            spend_nxt = job.scroll;
            state_nxt = att_pkg::SQ_CLR;
          end else if (job.scroll) begin
            sr_nxt    = RW'(1);
            state_nxt = att_pkg::SQ_SCR;
          end else begin
            state_nxt = att_pkg::SQ_FIN;
          end
        end
      end
      att_pkg::SQ_RD: begin
        char_nxt  = rdok_r ? rdata : 8'd0;
        state_nxt = att_pkg::SQ_FIN;
      end
      att_pkg::SQ_CLR: begin
        if (row_open) begin
          sc_nxt = sc_r + 1'b1;
        end else if (!last_row) begin
          sr_nxt = sr_r + 1'b1;
          sc_nxt = '0;
        end else if (init_r) begin
          init_nxt  = 1'b0;
          state_nxt = att_pkg::SQ_IDLE;
        end else if (spend_r) begin
          spend_nxt = 1'b0;
          sr_nxt    = RW'(1);
          sc_nxt    = '0;
          state_nxt = att_pkg::SQ_SCR;
        end else begin
          state_nxt = att_pkg::SQ_FIN;
        end
      end
      att_pkg::SQ_SCR: begin
        if (row_open) begin
          cpv_nxt = 1'b1;
          cpa_nxt = sweep_addr - AW'(MAXC);
          sc_nxt  = sc_r + 1'b1;
        end else if (32'(sr_r) == ROWS - 1) begin
          state_nxt = att_pkg::SQ_SCRW;
        end else begin
          sr_nxt = sr_r + 1'b1;
          sc_nxt = '0;
        end
      end
      att_pkg::SQ_SCRW: begin
        sr_nxt    = RW'(ROWS - 1);
        er_nxt    = RW'(ROWS - 1);
        sc_nxt    = '0;
        state_nxt = att_pkg::SQ_CLR;
      end
      att_pkg::SQ_FIN: begin
        if (out_free) state_nxt = att_pkg::SQ_IDLE;
      end
      default: state_nxt = att_pkg::SQ_IDLE;
    endcase
  end

  // Memory ports and handshake outputs
  always_comb begin
    we       = 1'b0;
    waddr    = sweep_addr;
    wdata    = att_pkg::CH_SPACE;
    raddr    = sweep_addr;
    in_ready = 1'b0;
    out_load = 1'b0;
    if (cpv_r) begin
      we    = 1'b1;
      waddr = cpa_r;
      wdata = rdata;
    end
    unique case (state_r)
      att_pkg::SQ_IDLE: begin
        in_ready = 1'b1;
        raddr    = rd_addr;
        if (take && !is_read && job.wr) begin
          we    = 1'b1;
          waddr = job_addr;
          wdata = job.wdata;
        end
      end
      att_pkg::SQ_CLR: begin
        if (row_open) we = 1'b1;
      end
      att_pkg::SQ_FIN: out_load = out_free;
      default: begin
      end
    endcase
  end

  // Hold sequencer registers; reset starts the grid clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= att_pkg::SQ_CLR;
      sr_r    <= '0;
      er_r    <= RW'(ROWS - 1);
      sc_r    <= '0;
      lim_r   <= CW'(MAXC);
      init_r  <= 1'b1;
      spend_r <= 1'b0;
      cpv_r   <= 1'b0;
      rdok_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sr_r    <= sr_nxt;
      er_r    <= er_nxt;
      sc_r    <= sc_nxt;
      lim_r   <= lim_nxt;
      init_r  <= init_nxt;
      spend_r <= spend_nxt;
      cpv_r   <= cpv_nxt;
      rdok_r  <= rdok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cpa_r  <= cpa_nxt;
    char_r <= char_nxt;
  end

  assign rd_char = char_r;

endmodule

>>> src/ansi_text_terminal_grid_unit.sv
// Top level of the text terminal grid: config registers, parser, sequencer, grid, output word.
// A put with no grid work goes straight to the output word; a read first fetches its cell.
// Clear screen sweeps all scrollback rows over the visible columns, clear to end of line the
// cursor row from the cursor on; a scroll copies rows up, clears the last; one cell a cycle.
// Throughput: one word at a time; not ready from acceptance until the result is registered.
// Reset (synchronous): clears the grid to spaces, not ready until the clearing pass ends.
module ansi_text_terminal_grid_unit #(
  parameter int SCROLLBACK_ROWS = att_pkg::SCROLLBACK_ROWS_DEF,
  parameter int MAX_COLS        = att_pkg::MAX_COLS_DEF,
  parameter int PARAM_CHARS     = att_pkg::PARAM_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  att_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output att_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [att_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);

  localparam int RW    = $clog2(SCROLLBACK_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int DEPTH = SCROLLBACK_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0] vcols_r, vrows_r;
  logic [31:0] ce, re;
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;
  logic take, put_take, out_free, out_load;
  att_pkg::job_t job;
  logic [RW-1:0] job_row, cur_row, act_rows;
  logic [CW-1:0] job_col, cur_col;
  logic [1:0] mode;
  logic [7:0] rd_char;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;
  logic out_valid_r;
  att_pkg::out_item_t out_data_r;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcols_r <= att_pkg::VISIBLE_COLS_RST;
      vrows_r <= att_pkg::VISIBLE_ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == att_pkg::CFG_VISIBLE_COLS) vcols_r <= cfg_wdata;
      if (cfg_index == att_pkg::CFG_VISIBLE_ROWS) vrows_r <= cfg_wdata;
    end
  end

  // Clamp the visible size
  always_comb begin
    ce = 32'(vcols_r);
    re = 32'(vrows_r);
    if (ce < 32'd1) ce = 32'd1;
    if (ce > 32'(MAX_COLS)) ce = 32'(MAX_COLS);
    if (re < 32'd1) re = 32'd1;
    if (re > 32'(SCROLLBACK_ROWS)) re = 32'(SCROLLBACK_ROWS);
  end
  assign cols_eff = CW'(ce);
  assign rows_eff = RW'(re);

  assign take     = in_valid && in_ready;
  assign put_take = take && (in_data.opcode == att_pkg::OP_PUT);
  assign out_free = !out_valid_r || out_ready;

  att_parser #(
    .ROWS(SCROLLBACK_ROWS), .PCHARS(PARAM_CHARS), .RW(RW), .CW(CW)
  ) u_parser (
    .clk(clk), .rst_n(rst_n), .take(put_take), .ch(in_data.char_code),
    .cols_eff(cols_eff), .rows_eff(rows_eff), .job(job), .job_row(job_row),
    .job_col(job_col), .cur_row(cur_row), .cur_col(cur_col), .act_rows(act_rows),
    .mode(mode)
  );

  att_sweep #(
    .ROWS(SCROLLBACK_ROWS), .MAXC(MAX_COLS), .RW(RW), .CW(CW), .AW(AW)
  ) u_sweep (
    .clk(clk), .rst_n(rst_n), .take(take),
    .is_read(in_data.opcode == att_pkg::OP_READ),
    .rd_row(in_data.read_row), .rd_col(in_data.read_col), .job(job),
    .job_row(job_row), .job_col(job_col), .cols_eff(cols_eff), .out_free(out_free),
    .in_ready(in_ready), .out_load(out_load), .rd_char(rd_char), .we(we), .waddr(waddr),
    .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  att_grid_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.cell_char      <= rd_char;
      out_data_r.cursor_row_out <= 7'(cur_row);
      out_data_r.cursor_col_out <= 8'(cur_col);
      out_data_r.rows_in_use    <= 8'(act_rows);
      out_data_r.parser_mode    <= mode;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
